>>> design/dqvl_pkg.sv
// Package for the dq voltage vector limiter: widths and Q0.16 constants.
// No dependencies.
`timescale 1ns / 1ps
package dqvl_pkg;
  localparam int unsigned VoltWidth    = 20;
  localparam int unsigned FracBits     = 6;
  localparam int unsigned OmegaWidth   = 24;
  localparam int unsigned InvSqrt3Q16  = 37838;
  localparam int unsigned CapQ16       = 62259;
  localparam int unsigned ConstWidth   = 16;
endpackage

>>> design/dqvl_if.sv
// Valid/ready channel interfaces for the limiter input and output words.
// Depends on dqvl_pkg.
`timescale 1ns / 1ps
interface dqvl_in_if #(
  parameter int unsigned VoltWidth = dqvl_pkg::VoltWidth
);
  logic                                   valid;
  logic                                   ready;
  logic signed [VoltWidth-1:0]            u_d;
  logic signed [VoltWidth-1:0]            u_q;
  logic        [VoltWidth-2:0]            dc_link;
  logic signed [dqvl_pkg::OmegaWidth-1:0] omega;
  logic signed [VoltWidth-1:0]            i_q;
  modport source (output valid, u_d, u_q, dc_link, omega, i_q, input ready);
  modport sink (input valid, u_d, u_q, dc_link, omega, i_q, output ready);
endinterface

interface dqvl_out_if #(
  parameter int unsigned VoltWidth = dqvl_pkg::VoltWidth
);
  logic                        valid;
  logic                        ready;
  logic signed [VoltWidth-1:0] out_d;
  logic signed [VoltWidth-1:0] out_q;
  logic                        clamped;
  modport source (output valid, out_d, out_q, clamped, input ready);
  modport sink (input valid, out_d, out_q, clamped, output ready);
endinterface

>>> design/dqvl_sqrt_cell.sv
// One cell of the pipelined restoring square root: resolves one result bit.
// Carries the word's side data alongside. No package use.
`timescale 1ns / 1ps
module dqvl_sqrt_cell #(
  parameter int unsigned RadWidth  = 40,
  parameter int unsigned RootWidth = 20,
  parameter int unsigned SideWidth = 8,
  parameter int unsigned BitPos    = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [RadWidth-1:0]  rem_i,
  input  logic [RootWidth-1:0] root_i,
  input  logic [SideWidth-1:0] side_i,
  output logic                 valid_o,
  output logic [RadWidth-1:0]  rem_o,
  output logic [RootWidth-1:0] root_o,
  output logic [SideWidth-1:0] side_o
);
  // trial = (2*root + 2^BitPos) << BitPos, root holds only higher bits
  logic [RadWidth+1:0] trial;
  logic [RadWidth-1:0] rem_d;
  logic [RootWidth-1:0] root_d;

  always_comb begin
    trial = ({2'b0, RadWidth'(root_i)} << (BitPos + 1))
          + ((RadWidth+2)'(1) << (2 * BitPos));
    rem_d  = rem_i;
    root_d = root_i;
    if ({2'b0, rem_i} >= trial) begin
      rem_d  = rem_i - trial[RadWidth-1:0];
      root_d = root_i | (RootWidth'(1) << BitPos);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
      side_o <= side_i;
    end
  end
endmodule

>>> design/dq_voltage_vector_limiter_top.sv
// dq voltage vector limiter, top level. Depends on dqvl_pkg, dqvl_if, dqvl_sqrt_cell.
//
// Accepts one word per cycle while the output is not stalled and delivers one
// result word per input word, in order. The path is 5 front stages plus
// VoltWidth-1 square-root cells plus the output register; the whole pipeline
// moves in lockstep and stalls only when the output word is not taken. The
// limit L = dc_link/sqrt3 (Q0.16), the cap 0.95*L, the squares and the
// magnitude test run in the front stages; the floor square root of L^2 - p^2
// is a chain of cells, one result bit per cell. Zero sign counts as its own
// sign for the d/q priority.
`timescale 1ns / 1ps
module dq_voltage_vector_limiter_top #(
  parameter int unsigned VoltWidth = dqvl_pkg::VoltWidth,
  parameter int unsigned FracBits  = dqvl_pkg::FracBits
) (
  input logic clk_i,
  input logic rst_ni,
  dqvl_in_if.sink    in_i,
  dqvl_out_if.source out_o
);
  localparam int unsigned W    = VoltWidth;
  localparam int unsigned CW   = dqvl_pkg::ConstWidth;
  localparam int unsigned RW   = 2 * W;        // radicand width
  localparam int unsigned NC   = W - 1;        // root bits (L < 2^(W-1))
  // side data: out_p(W) sign_o(2) prio_d(1) clamped(1)
  localparam int unsigned SW   = W + 4;
  localparam int unsigned FracUnused = FracBits; // shared scale, no arithmetic

  logic adv;
  assign adv = out_o.ready || !out_o.valid;
  assign in_i.ready = adv;

  function automatic logic [1:0] sgn2(input logic neg, input logic nz);
    sgn2 = {neg, nz};
  endfunction

  // stage 1: capture, limit product
  logic              v1_q;
  logic signed [W-1:0] d1_q, q1_q;
  logic [W-2+CW:0]   lp1_q;
  logic              pd1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_i.valid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_q  <= in_i.u_d;
      q1_q  <= in_i.u_q;
      lp1_q <= (W-1+CW)'(in_i.dc_link) * (W-1+CW)'(dqvl_pkg::InvSqrt3Q16);
      pd1_q <= sgn2(in_i.omega[dqvl_pkg::OmegaWidth-1], |in_i.omega)
            == sgn2(in_i.i_q[W-1], |in_i.i_q);
    end
  end

  // stage 2: L, magnitudes, cap product
  logic v2_q, pd2_q;
  logic signed [W-1:0] d2_q, q2_q;
  logic [W-2:0] l2_q;
  logic [W-1:0] md2_q, mq2_q;
  logic [W-2+CW:0] cp2_q;
  logic [W-2:0] l1;
  assign l1 = lp1_q[W-2+CW:CW];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pd2_q <= pd1_q; d2_q <= d1_q; q2_q <= q1_q; l2_q <= l1;
      md2_q <= d1_q[W-1] ? W'(-d1_q) : W'(d1_q);
      mq2_q <= q1_q[W-1] ? W'(-q1_q) : W'(q1_q);
      cp2_q <= (W-1+CW)'(l1) * (W-1+CW)'(dqvl_pkg::CapQ16);
    end
  end

  // stage 3: squares, cap, priority selection
  logic v3_q, pd3_q;
  logic signed [W-1:0] d3_q, q3_q, p3_q;
  logic [RW-1:0] sd3_q, sq3_q, sl3_q;
  logic [W-1:0] mp3_q;
  logic [1:0] so3_q;
  logic [W-2:0] cap2;
  assign cap2 = cp2_q[W-2+CW:CW];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pd3_q <= pd2_q; d3_q <= d2_q; q3_q <= q2_q;
      sd3_q <= RW'(md2_q) * RW'(md2_q);
      sq3_q <= RW'(mq2_q) * RW'(mq2_q);
      sl3_q <= RW'(l2_q) * RW'(l2_q);
      if (pd2_q) begin
        so3_q <= sgn2(q2_q[W-1], |q2_q);
        if (md2_q > W'(cap2)) begin
          mp3_q <= W'(cap2);
          p3_q  <= d2_q[W-1] ? -$signed(W'(cap2)) : $signed(W'(cap2));
        end else begin
          mp3_q <= md2_q; p3_q <= d2_q;
        end
      end else begin
        so3_q <= sgn2(d2_q[W-1], |d2_q);
        if (mq2_q > W'(cap2)) begin
          mp3_q <= W'(cap2);
          p3_q  <= q2_q[W-1] ? -$signed(W'(cap2)) : $signed(W'(cap2));
        end else begin
          mp3_q <= mq2_q; p3_q <= q2_q;
        end
      end
    end
  end

  // stage 4: compare sum, p'^2
  logic v4_q, pd4_q, cl4_q;
  logic signed [W-1:0] d4_q, q4_q, p4_q;
  logic [RW-1:0] sl4_q, sp4_q;
  logic [1:0] so4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pd4_q <= pd3_q; d4_q <= d3_q; q4_q <= q3_q; p4_q <= p3_q;
      so4_q <= so3_q; sl4_q <= sl3_q;
      cl4_q <= ({1'b0, sd3_q} + {1'b0, sq3_q}) > {1'b0, sl3_q};
      sp4_q <= RW'(mp3_q) * RW'(mp3_q);
    end
  end

  // stage 5: radicand and side word for the root chain
  logic v5_q;
  logic [RW-1:0] rad5_q;
  logic [SW-1:0] side5_q;
  logic signed [W-1:0] pass_d, pass_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad5_q  <= sl4_q - sp4_q;
      // unclamped: carry d in out_p field, q rides its own delay line
      side5_q <= cl4_q ? {p4_q, so4_q, pd4_q, 1'b1} : {d4_q, 2'b00, 1'b0, 1'b0};
    end
  end
  // unclamped q travels in its own delay line
  logic signed [W-1:0] qd_q [NC+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      qd_q[0] <= q4_q;
      for (int i = 1; i <= NC; i++) qd_q[i] <= qd_q[i-1];
    end
  end
  assign pass_d = '0;
  assign pass_q = '0;

  // root chain, most significant bit first
  logic          cv [NC+1];
  logic [RW-1:0] cr [NC+1];
  logic [W-1:0]  ct [NC+1];
  logic [SW-1:0] cs [NC+1];
  assign cv[0] = v5_q;
  assign cr[0] = rad5_q;
  assign ct[0] = '0;
  assign cs[0] = side5_q;
  for (genvar g = 0; g < NC; g++) begin : g_cell
    dqvl_sqrt_cell #(
      .RadWidth(RW), .RootWidth(W), .SideWidth(SW), .BitPos(NC - 1 - g)
    ) u_cell (
      .clk_i, .rst_ni, .en_i(adv),
      .valid_i(cv[g]), .rem_i(cr[g]), .root_i(ct[g]), .side_i(cs[g]),
      .valid_o(cv[g+1]), .rem_o(cr[g+1]), .root_o(ct[g+1]), .side_o(cs[g+1])
    );
  end

  // output assembly
  logic signed [W-1:0] p_f, o_f, rd_d, rq_d;
  logic [1:0] so_f;
  logic pd_f, cl_f;
  always_comb begin
    p_f  = cs[NC][SW-1:4];
    so_f = cs[NC][3:2];
    pd_f = cs[NC][1];
    cl_f = cs[NC][0];
    o_f  = !so_f[0] ? '0 : (so_f[1] ? -$signed(ct[NC]) : $signed(ct[NC]));
    rd_d = p_f | pass_d;
    rq_d = qd_q[NC] | pass_q;
    if (cl_f) begin
      rd_d = pd_f ? p_f : o_f;
      rq_d = pd_f ? o_f : p_f;
    end
  end

  logic vo_q;
  logic signed [W-1:0] od_q, oq_q;
  logic cl_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (adv) vo_q <= cv[NC];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      od_q <= rd_d; oq_q <= rq_d; cl_q <= cl_f && (FracUnused < 64);
    end
  end
  assign out_o.valid   = vo_q;
  assign out_o.out_d   = od_q;
  assign out_o.out_q   = oq_q;
  assign out_o.clamped = cl_q;
endmodule

>>> design/dqvl_checker.sv
// Port-level checker for the limiter, bound to the top level.
// Depends on dq_voltage_vector_limiter_top (bind target) and dqvl_if.
`timescale 1ns / 1ps
module dqvl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_clamped,
  input logic [19:0] out_d,
  input logic [19:0] out_q
);
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("input stalled with empty output");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_d) && $stable(out_q)
      && $stable(out_clamped))
    else $error("stalled output word changed");
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !out_valid)
    else $error("output valid after reset");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready) else $error("input taken while stalled");
endmodule

bind dq_voltage_vector_limiter_top dqvl_checker u_dqvl_checker (
  .clk_i, .rst_ni,
  .in_ready(in_i.ready), .out_valid(out_o.valid), .out_ready(out_o.ready),
  .out_clamped(out_o.clamped), .out_d(20'(out_o.out_d)), .out_q(20'(out_o.out_q))
);
